@@ rtl/srt_pkg.sv @@
// Shared types, constants and the half-step coil table for the stepper axis rate tracker.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // Field widths
  localparam int unsigned ErrW     = 16;
  localparam int unsigned MagW     = ErrW + 1;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IvW      = 16;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CoilW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = 2 * IvW;

  // Divider: quotient is known to fit IvW bits, so IvW restoring steps suffice
  localparam int unsigned DivSteps = IvW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register reset values
  localparam logic [CfgDataW-1:0] DeadbandRst = 16'd50;
  localparam logic [CfgDataW-1:0] MaxErrRst   = 16'd1000;
  localparam logic [CfgDataW-1:0] FastRst     = 16'd2;
  localparam logic [CfgDataW-1:0] SlowRst     = 16'd20;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REVERSE  = 3'd0,
    CFG_DEADBAND = 3'd1,
    CFG_MAX_ERR  = 3'd2,
    CFG_FASTEST  = 3'd3,
    CFG_SLOWEST  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                reverse;
    logic [CfgDataW-1:0] deadband;
    logic [CfgDataW-1:0] max_error;
    logic [CfgDataW-1:0] fastest;
    logic [CfgDataW-1:0] slowest;
  } cfg_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // Divider status from divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Half-step coil sequence
  function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/srt_if.sv @@
// Valid/ready channel interfaces for the tracker's input and result beats.
// Depends on srt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface srt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srt_pkg::ErrW-1:0]      angle_error;
  logic                                 tracking;
  logic        [srt_pkg::TimeW-1:0]     time_now;

  modport source (output valid, angle_error, tracking, time_now, input ready);
  modport sink   (input valid, angle_error, tracking, time_now, output ready);
endinterface

interface srt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          stepped;
  logic [srt_pkg::CoilW-1:0]     coil_pattern;
  logic [srt_pkg::PhaseW-1:0]    phase_index;

  modport source (output valid, stepped, coil_pattern, phase_index, input ready);
  modport sink   (input valid, stepped, coil_pattern, phase_index, output ready);
endinterface

`default_nettype wire

@@ rtl/srt_cfg_regs.sv @@
// Configuration register file: five write-only registers with their reset values.
// Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [srt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [srt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output srt_pkg::cfg_t                       cfg_o
);

  srt_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse   <= 1'b0;
      cfg_q.deadband  <= srt_pkg::DeadbandRst;
      cfg_q.max_error <= srt_pkg::MaxErrRst;
      cfg_q.fastest   <= srt_pkg::FastRst;
      cfg_q.slowest   <= srt_pkg::SlowRst;
    end else if (cfg_we_i) begin
      case (srt_pkg::cfg_idx_e'(cfg_idx_i))
        srt_pkg::CFG_REVERSE:  cfg_q.reverse   <= cfg_wdata_i[0];
        srt_pkg::CFG_DEADBAND: cfg_q.deadband  <= cfg_wdata_i;
        srt_pkg::CFG_MAX_ERR:  cfg_q.max_error <= cfg_wdata_i;
        srt_pkg::CFG_FASTEST:  cfg_q.fastest   <= cfg_wdata_i;
        srt_pkg::CFG_SLOWEST:  cfg_q.slowest   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/srt_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Caller guarantees dividend < divisor * 2^IvW so the quotient fits IvW bits. Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [srt_pkg::ProdW-1:0]   dividend_i,
  input  wire logic [srt_pkg::IvW-1:0]     divisor_i,
  output srt_pkg::div_stat_t               stat_o,
  output logic      [srt_pkg::IvW-1:0]     quotient_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [srt_pkg::DivCntW-1:0]   cnt_q;
  logic [srt_pkg::IvW-1:0]       rem_q;
  logic [srt_pkg::IvW-1:0]       quo_q;
  logic [srt_pkg::IvW-1:0]       dvs_q;

  logic [srt_pkg::IvW:0]         shifted;
  logic [srt_pkg::IvW:0]         trial;
  logic                          qbit;
  logic [srt_pkg::IvW-1:0]       rem_d;
  logic                          last;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[srt_pkg::IvW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign qbit    = (shifted >= {1'b0, dvs_q});
  assign rem_d   = qbit ? trial[srt_pkg::IvW-1:0] : shifted[srt_pkg::IvW-1:0];
  assign last    = (cnt_q == srt_pkg::DivCntW'(srt_pkg::DivSteps - 1));

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + srt_pkg::DivCntW'(1);
        if (last) busy_q <= 1'b0;
      end
    end
  end

  // Datapath: remainder, quotient/dividend shift register, held divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[srt_pkg::ProdW-1:srt_pkg::IvW];
      quo_q <= dividend_i[srt_pkg::IvW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[srt_pkg::IvW-2:0], qbit};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/stepper_axis_rate_tracker_top.sv @@
// Top level of the half-step stepper axis rate tracker: sequencer, phase and due-time state.
// Depends on srt_pkg, srt_if, srt_cfg_regs and srt_divider.
//
//  channel   dir  handshake         payload
//  in_i      in   valid/ready       angle_error[15:0] s, tracking, time_now[31:0]
//  out_o     out  valid/ready       stepped, coil_pattern[3:0], phase_index[2:0]
//  cfg       in   cfg_we_i only     cfg_idx_i[2:0], cfg_wdata_i[15:0]
//
// One item at a time: a beat that needs no interpolation goes straight from accept to the
// write-back state; one in the linear region passes the multiply state, 16 divider steps
// of one quotient bit per cycle and the divider's done flag before write-back.
// in_i.ready is high only while the sequencer is idle. Reset is asynchronous, active low,
// and clears phase, due time and the result valid. A stalled result holds the sequencer
// in its write-back state until out_o is taken.
`timescale 1ns / 1ps
`default_nettype none

module stepper_axis_rate_tracker_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  srt_in_if.sink                             in_i,
  srt_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [srt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [srt_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  srt_pkg::cfg_t               cfg;
  srt_pkg::state_e             state_q;
  srt_pkg::div_stat_t          div_stat;

  logic [srt_pkg::PhaseW-1:0]  phase_q;
  logic [srt_pkg::TimeW-1:0]   due_q;
  logic                        out_valid_q;
  logic                        res_step_q;
  logic [srt_pkg::PhaseW-1:0]  res_phase_q;

  logic [srt_pkg::TimeW-1:0]   now_q;
  logic [srt_pkg::IvW-1:0]     ival_q;
  logic [srt_pkg::IvW-1:0]     diff_q;
  logic [srt_pkg::IvW-1:0]     span_q;
  logic                        step_flag_q;
  logic                        upd_due_q;

  logic                        accept;
  logic                        neg;
  logic [srt_pkg::MagW-1:0]    mag;
  logic [srt_pkg::MagW-1:0]    mag_off;
  logic                        quiet;
  logic [srt_pkg::TimeW-1:0]   since_due;
  logic                        due_ok;
  logic                        at_max;
  logic                        flat;
  logic                        inv;
  logic                        forward;
  logic [srt_pkg::PhaseW-1:0]  phase_next;
  logic                        wb_go;
  logic                        div_start;
  logic [srt_pkg::ProdW-1:0]   product;
  logic [srt_pkg::IvW-1:0]     quotient;

  srt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Combinational multiply feeds the divider, which registers it at start
  assign product   = diff_q * span_q;
  assign div_start = (state_q == srt_pkg::S_MUL);

  srt_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (cfg.max_error - cfg.deadband),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Input decode: magnitude, deadband, due test, interval region
  assign accept    = in_i.valid && in_i.ready;
  assign neg       = in_i.angle_error[srt_pkg::ErrW-1];
  assign mag       = neg ? (srt_pkg::MagW'(17'h10000) - {1'b0, in_i.angle_error})
                         : {1'b0, in_i.angle_error};
  assign mag_off   = mag - {1'b0, cfg.deadband};
  assign quiet     = !in_i.tracking || (mag <= {1'b0, cfg.deadband});
  assign since_due = in_i.time_now - due_q;
  assign due_ok    = !since_due[srt_pkg::TimeW-1];
  assign at_max    = (mag >= {1'b0, cfg.max_error});
  assign flat      = (cfg.max_error <= cfg.deadband);
  assign inv       = (cfg.fastest > cfg.slowest);
  assign forward   = neg ^ cfg.reverse;
  assign phase_next = forward ? (phase_q + srt_pkg::PhaseW'(1))
                              : (phase_q - srt_pkg::PhaseW'(1));

  assign wb_go = (state_q == srt_pkg::S_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srt_pkg::S_IDLE;
      phase_q     <= '0;
      due_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Result valid: set on write-back, cleared when the beat is taken
      if (wb_go) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        srt_pkg::S_IDLE: begin
          if (accept) begin
            if (!quiet && due_ok) phase_q <= phase_next;
            if (!quiet && due_ok && !at_max && !flat && !inv) state_q <= srt_pkg::S_MUL;
            else state_q <= srt_pkg::S_DONE;
          end
        end
        srt_pkg::S_MUL:  state_q <= srt_pkg::S_DIV;
        srt_pkg::S_DIV: begin
          if (div_stat.done) state_q <= srt_pkg::S_DONE;
        end
        srt_pkg::S_DONE: begin
          if (wb_go) begin
            if (upd_due_q) due_q <= now_q + {{(srt_pkg::TimeW - srt_pkg::IvW){1'b0}}, ival_q};
            state_q <= srt_pkg::S_IDLE;
          end
        end
        default: state_q <= srt_pkg::S_IDLE;
      endcase
    end
  end

  // Per-item working registers and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q       <= in_i.time_now;
      step_flag_q <= !quiet && due_ok;
      upd_due_q   <= quiet || due_ok;
      diff_q      <= mag_off[srt_pkg::IvW-1:0];
      span_q      <= cfg.slowest - cfg.fastest;
      if (quiet)            ival_q <= '0;
      else if (at_max)      ival_q <= cfg.fastest;
      else                  ival_q <= cfg.slowest;
    end
    if ((state_q == srt_pkg::S_DIV) && div_stat.done) ival_q <= cfg.slowest - quotient;
    if (wb_go) begin
      res_step_q  <= step_flag_q;
      res_phase_q <= phase_q;
    end
  end

  assign in_i.ready         = (state_q == srt_pkg::S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.stepped      = res_step_q;
  assign out_o.phase_index  = res_phase_q;
  assign out_o.coil_pattern = srt_pkg::coil_of(res_phase_q);

  // Checks
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == srt_pkg::S_DIV))
    else $error("divider finished outside divide state");

  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == srt_pkg::S_DONE))
    else $error("result raised without write-back");

  a_phase_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q)) |-> $past(in_i.valid && in_i.ready))
    else $error("phase moved without an accepted beat");

endmodule

`default_nettype wire
